// ----- rtl/knot_interval_subdivider_macros.svh -----
`ifndef KNOT_INTERVAL_SUBDIVIDER_MACROS_SVH
`define KNOT_INTERVAL_SUBDIVIDER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define KIS_ASSERT_SAME(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("kis check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during rst
`define KIS_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("kis check failed: next-cycle implication");

`endif

// ----- rtl/kis_pkg.sv -----
package kis_pkg;

  localparam int KIND_W   = 3;
  localparam int SUBDIV_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [SUBDIV_W-1:0] SUBDIV_RESET = SUBDIV_W'(4);

  localparam logic [KIND_W-1:0] KIND_GRID = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOW  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HIGH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MINF = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LAST = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PINF = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBDIV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_HIGH = 2'd2;

endpackage

// ----- rtl/kis_ifs.sv -----
interface kis_knot_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] knot_value;
  logic                          final_knot;

  modport source (output valid, output knot_value, output final_knot, input ready);
  modport sink   (input valid, input knot_value, input final_knot, output ready);
endinterface

interface kis_point_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coordinate;
  logic [kis_pkg::KIND_W-1:0]    point_kind;
  logic                          run_end;

  modport source (output valid, output coordinate, output point_kind, output run_end,
                  input ready);
  modport sink   (input valid, input coordinate, input point_kind, input run_end,
                  output ready);
endinterface

interface kis_cfg_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [kis_pkg::CFG_IDX_W-1:0] index;
  logic [COORD_WIDTH-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/kis_div.sv -----
module kis_div #(
  parameter int DIVIDEND_W = 32,
  parameter int DIVISOR_W  = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;

  assign rem_sh   = {rem, quo[DIVIDEND_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/knot_interval_subdivider.sv -----
// Knot interval subdivider.
// knot_in carries one knot per beat (Q16.16 by default) with final_knot marking
// the last knot of a vector; pt_out carries the emitted points with point_kind
// and run_end set on the last point caused by a knot; cfg writes subdivisions,
// trim_low and trim_high by index and is always ready.
// The first knot of a vector gives a minus-infinity point through the S_MINF
// state and the output register. A knot above the previous one starts a
// radix-2 divider, then the sequencer walks the steps by adding the quotient,
// one point per cycle while the output register is free: subdivisions grid
// points, clamped to 1..MAX_SUBDIVISIONS, plus up to two trim points. A final
// knot adds the knot itself and a plus-infinity point.
// knot_in is ready only while the sequencer is idle.
// pt_out is driven from an output register: when the receiver stalls, the
// sequencer holds until the register frees, and the next knot may be taken
// while the last point still waits there.
// Reset is synchronous: config returns to subdivisions 4, trims 0, and a new
// vector begins.
module knot_interval_subdivider #(
  parameter int MAX_SUBDIVISIONS = 60,
  parameter int COORD_WIDTH      = 32
) (
  input  logic           clk,
  input  logic           rst,
  kis_knot_if.sink       knot_in,
  kis_point_if.source    pt_out,
  kis_cfg_if.sink        cfg
);

  localparam int STEP_W = $clog2(MAX_SUBDIVISIONS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_GRID = 3'd2;
  localparam logic [2:0] S_LOW  = 3'd3;
  localparam logic [2:0] S_HIGH = 3'd4;
  localparam logic [2:0] S_LAST = 3'd5;
  localparam logic [2:0] S_PINF = 3'd6;
  localparam logic [2:0] S_MINF = 3'd7;

  localparam logic signed [COORD_WIDTH-1:0] MIN_COORD = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic signed [COORD_WIDTH-1:0] MAX_COORD = ~MIN_COORD;

  logic [2:0]                       state;
  logic [kis_pkg::SUBDIV_W-1:0]     subdiv;
  logic signed [COORD_WIDTH-1:0]    trim_low;
  logic signed [COORD_WIDTH-1:0]    trim_high;
  logic signed [COORD_WIDTH-1:0]    prev_knot;
  logic                             started;
  logic                             low_pending;
  logic                             high_pending;
  logic signed [COORD_WIDTH-1:0]    knot;
  logic                             fin;
  logic [STEP_W-1:0]                steps;
  logic [STEP_W-1:0]                step_idx;
  logic [COORD_WIDTH-1:0]           delta;
  logic signed [COORD_WIDTH-1:0]    start_pt;
  logic signed [COORD_WIDTH-1:0]    end_pt;
  logic                             hit_high;

  logic                             ovalid;
  logic signed [COORD_WIDTH-1:0]    ocoord;
  logic [kis_pkg::KIND_W-1:0]       okind;
  logic                             orun_end;

  logic                             accept;
  logic                             slot_free;
  logic                             emit;
  logic                             rising;
  logic [STEP_W-1:0]                steps_eff;
  logic                             div_start;
  logic                             div_done;
  logic [COORD_WIDTH-1:0]           div_quo;
  logic                             low_hit;
  logic                             high_hit;
  logic                             last_step;

  assign knot_in.ready = (state == S_IDLE);
  assign accept        = knot_in.valid && knot_in.ready;
  assign slot_free     = !ovalid || pt_out.ready;
  assign emit          = slot_free && (state != S_IDLE) && (state != S_DIV);
  assign rising        = prev_knot < knot_in.knot_value;
  assign div_start     = accept && started && rising;

  assign cfg.ready = 1'b1;

  assign pt_out.valid      = ovalid;
  assign pt_out.coordinate = ocoord;
  assign pt_out.point_kind = okind;
  assign pt_out.run_end    = orun_end;

  always_comb begin
    if (subdiv == '0) begin
      steps_eff = STEP_W'(1);
    end else if (subdiv > kis_pkg::SUBDIV_W'(MAX_SUBDIVISIONS)) begin
      steps_eff = STEP_W'(MAX_SUBDIVISIONS);
    end else begin
      steps_eff = subdiv[STEP_W-1:0];
    end
  end

  assign low_hit   = low_pending && (start_pt < trim_low) && (trim_low < end_pt);
  assign high_hit  = high_pending && (start_pt < trim_high) && (trim_high < end_pt);
  assign last_step = (step_idx == steps - 1'b1);

  kis_div #(
    .DIVIDEND_W (COORD_WIDTH),
    .DIVISOR_W  (STEP_W)
  ) u_kis_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (COORD_WIDTH'(knot_in.knot_value - prev_knot)),
    .divisor  (steps_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      subdiv    <= kis_pkg::SUBDIV_RESET;
      trim_low  <= '0;
      trim_high <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        kis_pkg::CFG_SUBDIV:    subdiv    <= cfg.data[kis_pkg::SUBDIV_W-1:0];
        kis_pkg::CFG_TRIM_LOW:  trim_low  <= $signed(cfg.data);
        kis_pkg::CFG_TRIM_HIGH: trim_high <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (pt_out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_knot    <= '0;
      started      <= 1'b0;
      low_pending  <= 1'b1;
      high_pending <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            knot  <= knot_in.knot_value;
            fin   <= knot_in.final_knot;
            steps <= steps_eff;
            if (!started) begin
              state <= S_MINF;
            end else if (rising) begin
              state <= S_DIV;
            end else if (knot_in.final_knot) begin
              state <= S_LAST;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            delta    <= div_quo;
            start_pt <= prev_knot;
            end_pt   <= prev_knot + $signed(div_quo);
            step_idx <= '0;
            state    <= S_GRID;
          end
        end
        S_GRID: begin
          if (slot_free) begin
            ocoord   <= start_pt;
            okind    <= kis_pkg::KIND_GRID;
            orun_end <= last_step && !low_hit && !high_hit && !fin;
            hit_high <= high_hit;
            if (low_hit) begin
              state <= S_LOW;
            end else if (high_hit) begin
              state <= S_HIGH;
            end else if (last_step) begin
              prev_knot <= knot;
              state     <= fin ? S_LAST : S_IDLE;
            end else begin
              step_idx <= step_idx + 1'b1;
              start_pt <= end_pt;
              end_pt   <= end_pt + $signed(delta);
            end
          end
        end
        S_LOW: begin
          if (slot_free) begin
            ocoord      <= trim_low;
            okind       <= kis_pkg::KIND_LOW;
            orun_end    <= last_step && !hit_high && !fin;
            low_pending <= 1'b0;
            if (hit_high) begin
              state <= S_HIGH;
            end else if (last_step) begin
              prev_knot <= knot;
              state     <= fin ? S_LAST : S_IDLE;
            end else begin
              step_idx <= step_idx + 1'b1;
              start_pt <= end_pt;
              end_pt   <= end_pt + $signed(delta);
              state    <= S_GRID;
            end
          end
        end
        S_HIGH: begin
          if (slot_free) begin
            ocoord       <= trim_high;
            okind        <= kis_pkg::KIND_HIGH;
            orun_end     <= last_step && !fin;
            high_pending <= 1'b0;
            if (last_step) begin
              prev_knot <= knot;
              state     <= fin ? S_LAST : S_IDLE;
            end else begin
              step_idx <= step_idx + 1'b1;
              start_pt <= end_pt;
              end_pt   <= end_pt + $signed(delta);
              state    <= S_GRID;
            end
          end
        end
        S_MINF: begin
          if (slot_free) begin
            ocoord    <= MIN_COORD;
            okind     <= kis_pkg::KIND_MINF;
            orun_end  <= !fin;
            started   <= 1'b1;
            prev_knot <= knot;
            state     <= fin ? S_LAST : S_IDLE;
          end
        end
        S_LAST: begin
          if (slot_free) begin
            ocoord   <= knot;
            okind    <= kis_pkg::KIND_LAST;
            orun_end <= 1'b0;
            state    <= S_PINF;
          end
        end
        S_PINF: begin
          if (slot_free) begin
            ocoord       <= MAX_COORD;
            okind        <= kis_pkg::KIND_PINF;
            orun_end     <= 1'b1;
            started      <= 1'b0;
            low_pending  <= 1'b1;
            high_pending <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/kis_chk.sv -----
`include "knot_interval_subdivider_macros.svh"

module kis_chk #(
  parameter int COORD_WIDTH = 32
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [COORD_WIDTH-1:0]     coordinate,
  input logic [kis_pkg::KIND_W-1:0] point_kind,
  input logic                       run_end
);

  `KIS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coordinate) && $stable(point_kind) && $stable(run_end))
  `KIS_ASSERT_SAME(a_pinf_ends_run, out_valid && point_kind == kis_pkg::KIND_PINF, run_end)
  `KIS_ASSERT_NEXT(a_last_then_pinf, out_valid && out_ready && point_kind == kis_pkg::KIND_LAST, out_valid && point_kind == kis_pkg::KIND_PINF)
  `KIS_ASSERT_SAME(a_busy_at_last, out_valid && point_kind == kis_pkg::KIND_LAST, !in_ready)

endmodule

bind knot_interval_subdivider kis_chk #(
  .COORD_WIDTH (COORD_WIDTH)
) u_kis_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (knot_in.ready),
  .out_valid  (pt_out.valid),
  .out_ready  (pt_out.ready),
  .coordinate (pt_out.coordinate),
  .point_kind (pt_out.point_kind),
  .run_end    (pt_out.run_end)
);

// ----- tb/knot_interval_subdivider_tb.sv -----
module knot_interval_subdivider_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_SUB     = 60;
  localparam int  CW          = 32;
  localparam int  RANDOM_KNOTS = 320;
  localparam int  SETTLE      = 120;
  localparam int  TAIL        = 150;
  localparam int  HOLD_CYCLES = 400;
  localparam longint MAXV     = 64'sd2147483647;
  localparam longint MINV     = -64'sd2147483648;
  localparam logic [CW-1:0] MINUS_INF = 32'h8000_0000;
  localparam logic [CW-1:0] PLUS_INF  = 32'h7fff_ffff;

  typedef enum logic [1:0] {ACT_KNOT, ACT_CFG, ACT_DRAIN} act_t;

  typedef struct {
    act_t                          act;
    logic [CW-1:0]                 value;
    logic                          fin;
    logic [kis_pkg::CFG_IDX_W-1:0] index;
  } step_t;

  typedef struct packed {
    logic [CW-1:0]              coord;
    logic [kis_pkg::KIND_W-1:0] kind;
    logic                       last;
  } point_t;

  logic clk;
  logic rst;

  kis_knot_if  #(.COORD_WIDTH(CW)) knot_if ();
  kis_point_if #(.COORD_WIDTH(CW)) pt_if ();
  kis_cfg_if   #(.COORD_WIDTH(CW)) cfg_if ();

  knot_interval_subdivider #(
    .MAX_SUBDIVISIONS(MAX_SUB),
    .COORD_WIDTH(CW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .knot_in(knot_if),
    .pt_out(pt_if),
    .cfg(cfg_if)
  );

  step_t  schedule[$];
  point_t pending_points[$];

  logic [kis_pkg::SUBDIV_W-1:0] div_setting;
  logic signed [CW-1:0] trim_lo;
  logic signed [CW-1:0] trim_hi;
  logic signed [CW-1:0] prev_knot;
  logic in_vector;
  logic low_pend;
  logic high_pend;

  int mismatches = 0;
  int points_seen = 0;
  int knots_taken;
  int writes_taken = 0;
  int planned = 0;
  int burst_left;
  int gap_left;
  int quiet;
  int hold_left;
  int holds_done;
  int rx_cycle;

  always #2 clk = ~clk;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [CW-1:0] clamp32(input longint v);
    if (v > MAXV) return PLUS_INF;
    if (v < MINV) return MINUS_INF;
    return v[CW-1:0];
  endfunction

  task automatic put_knot(input longint v, input logic fin);
    schedule.push_back('{ACT_KNOT, clamp32(v), fin, kis_pkg::CFG_SUBDIV});
    planned++;
  endtask

  task automatic put_cfg(input logic [kis_pkg::CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    schedule.push_back('{ACT_CFG, data, 1'b0, idx});
  endtask

  task automatic put_drain();
    schedule.push_back('{ACT_DRAIN, '0, 1'b0, kis_pkg::CFG_SUBDIV});
  endtask

  task automatic apply_register(input logic [kis_pkg::CFG_IDX_W-1:0] idx,
                                input logic [CW-1:0] data);
    case (idx)
      kis_pkg::CFG_SUBDIV:    div_setting = data[kis_pkg::SUBDIV_W-1:0];
      kis_pkg::CFG_TRIM_LOW:  trim_lo = data;
      kis_pkg::CFG_TRIM_HIGH: trim_hi = data;
      default: ;
    endcase
    writes_taken++;
  endtask

  task automatic tessellate_knot(input logic signed [CW-1:0] knot, input logic fin);
    point_t run[$];
    longint kv, prev, span_len, delta, start, stop, lo, hi;
    int steps, j;
    kv = knot;
    prev = prev_knot;
    lo = trim_lo;
    hi = trim_hi;
    if (!in_vector) begin
      run.push_back('{MINUS_INF, kis_pkg::KIND_MINF, 1'b0});
      in_vector = 1'b1;
      prev_knot = knot;
    end else if (prev < kv) begin
      steps = int'(div_setting);
      if (steps == 0) steps = 1;
      if (steps > MAX_SUB) steps = MAX_SUB;
      span_len = kv - prev;
      delta = span_len / steps;
      start = prev;
      for (j = 0; j < steps; j++) begin
        stop = start + delta;
        run.push_back('{start[CW-1:0], kis_pkg::KIND_GRID, 1'b0});
        if (low_pend && start < lo && lo < stop) begin
          run.push_back('{trim_lo, kis_pkg::KIND_LOW, 1'b0});
          low_pend = 1'b0;
        end
        if (high_pend && start < hi && hi < stop) begin
          run.push_back('{trim_hi, kis_pkg::KIND_HIGH, 1'b0});
          high_pend = 1'b0;
        end
        start = stop;
      end
      prev_knot = knot;
    end
    if (fin) begin
      run.push_back('{knot, kis_pkg::KIND_LAST, 1'b0});
      run.push_back('{PLUS_INF, kis_pkg::KIND_PINF, 1'b0});
      in_vector = 1'b0;
      low_pend = 1'b1;
      high_pend = 1'b1;
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) pending_points.push_back(run[i]);
  endtask

  always @(posedge clk) begin : driver
    step_t head;
    logic offer_knot;
    logic offer_cfg;
    if (rst) begin
      knot_if.valid <= 1'b0;
      knot_if.knot_value <= '0;
      knot_if.final_knot <= 1'b0;
      cfg_if.valid <= 1'b0;
      cfg_if.index <= kis_pkg::CFG_SUBDIV;
      cfg_if.data <= '0;
      knots_taken <= 0;
      div_setting = kis_pkg::SUBDIV_RESET;
      trim_lo = '0;
      trim_hi = '0;
      prev_knot = '0;
      in_vector = 1'b0;
      low_pend = 1'b1;
      high_pend = 1'b1;
      burst_left = $urandom_range(1, 8);
      gap_left = 0;
      quiet = 0;
    end else begin
      if (knot_if.valid && knot_if.ready) begin
        tessellate_knot(knot_if.knot_value, knot_if.final_knot);
        schedule.delete(0);
        knots_taken <= knots_taken + 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        apply_register(cfg_if.index, cfg_if.data);
        schedule.delete(0);
      end
      offer_knot = 1'b0;
      offer_cfg = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (schedule.size() > 0) begin
        head = schedule[0];
        case (head.act)
          ACT_KNOT: offer_knot = 1'b1;
          ACT_CFG:  offer_cfg = 1'b1;
          default: begin
            quiet = (pending_points.size() == 0) ? quiet + 1 : 0;
            if (quiet >= SETTLE) begin
              schedule.delete(0);
              quiet = 0;
            end
          end
        endcase
      end
      knot_if.valid <= offer_knot;
      if (offer_knot) begin
        knot_if.knot_value <= head.value;
        knot_if.final_knot <= head.fin;
      end
      cfg_if.valid <= offer_cfg;
      if (offer_cfg) begin
        cfg_if.index <= head.index;
        cfg_if.data <= head.value;
      end
    end
  end

  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && knot_if.valid && knots_taken >= 120 + 140 * holds_done) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin : monitor
    point_t want;
    logic go;
    if (rst) begin
      pt_if.ready <= 1'b0;
      rx_cycle = 0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        points_seen++;
        if (pending_points.size() == 0) begin
          report($sformatf("unexpected beat coord %h kind %0d", pt_if.coordinate,
                           pt_if.point_kind));
        end else begin
          want = pending_points.pop_front();
          if (pt_if.coordinate !== want.coord)
            report($sformatf("coordinate %h, want %h", pt_if.coordinate, want.coord));
          if (pt_if.point_kind !== want.kind)
            report($sformatf("point_kind %0d, want %0d", pt_if.point_kind, want.kind));
          if (pt_if.run_end !== want.last)
            report($sformatf("run_end %b, want %b", pt_if.run_end, want.last));
        end
      end
      rx_cycle++;
      case ((rx_cycle / 97) % 4)
        0:       go = 1'b1;
        1:       go = $urandom_range(0, 1) == 1;
        2:       go = $urandom_range(0, 3) == 0;
        default: go = (rx_cycle % 3) != 0;
      endcase
      pt_if.ready <= go && (hold_left == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    longint span, base, cur, lo, hi, v;
    int pick, sc, nvec, len, r, start_planned;
    logic noise;
    logic [kis_pkg::SUBDIV_W-1:0] subdiv;
    clk = 1'b0;
    rst = 1'b1;

    put_knot(-65536, 1'b0);
    put_knot(65536, 1'b1);
    put_knot(MAXV, 1'b1);

    put_drain();
    put_cfg(kis_pkg::CFG_SUBDIV, 60);
    put_cfg(kis_pkg::CFG_TRIM_LOW, -1000000);
    put_cfg(kis_pkg::CFG_TRIM_HIGH, 2000000000);
    put_knot(MINV, 1'b0);
    put_knot(MAXV, 1'b1);

    put_drain();
    put_cfg(kis_pkg::CFG_SUBDIV, 0);
    put_cfg(kis_pkg::CFG_TRIM_LOW, 5);
    put_cfg(kis_pkg::CFG_TRIM_HIGH, 3);
    put_knot(0, 1'b0);
    put_knot(10, 1'b1);

    put_drain();
    put_cfg(kis_pkg::CFG_SUBDIV, 4);
    put_cfg(kis_pkg::CFG_TRIM_LOW, 9);
    put_cfg(kis_pkg::CFG_TRIM_HIGH, 1);
    put_knot(0, 1'b0);
    put_knot(10, 1'b0);
    put_knot(10, 1'b0);
    put_knot(7, 1'b0);
    put_knot(13, 1'b0);
    put_knot(13, 1'b1);

    put_drain();
    put_cfg(kis_pkg::CFG_SUBDIV, 63);
    put_cfg(kis_pkg::CFG_TRIM_LOW, 32'h0001_2345);
    put_cfg(kis_pkg::CFG_TRIM_HIGH, -32'sh0001_2345);
    put_knot(-64'sh10_0000, 1'b0);
    put_knot(-64'sh20_0000, 1'b0);
    put_knot(64'sh10_0000, 1'b0);
    put_knot(-5, 1'b1);

    start_planned = planned;
    while (planned - start_planned < RANDOM_KNOTS) begin
      put_drain();
      pick = $urandom_range(0, 9);
      if (pick < 6) subdiv = kis_pkg::SUBDIV_W'($urandom_range(1, 8));
      else if (pick == 6)
        subdiv = kis_pkg::SUBDIV_W'($urandom_range(0, 1) ? 0 : $urandom_range(61, 63));
      else if (pick == 7) subdiv = kis_pkg::SUBDIV_W'($urandom_range(50, 60));
      else subdiv = kis_pkg::SUBDIV_W'($urandom_range(9, 40));
      sc = $urandom_range(3, 31);
      span = 64'sd1 << sc;
      base = longint'(int'($urandom));
      if (base > MAXV - span) base = MAXV - span;
      lo = base + longint'($urandom) % span;
      hi = base + longint'($urandom) % span;
      if ($urandom_range(0, 4) == 0) lo = longint'(int'($urandom));
      if ($urandom_range(0, 4) == 0) hi = longint'(int'($urandom));
      put_cfg(kis_pkg::CFG_SUBDIV, CW'(subdiv));
      put_cfg(kis_pkg::CFG_TRIM_LOW, clamp32(lo));
      put_cfg(kis_pkg::CFG_TRIM_HIGH, clamp32(hi));
      nvec = $urandom_range(2, 4);
      repeat (nvec) begin
        len = $urandom_range(1, 8);
        noise = $urandom_range(0, 9) == 0;
        cur = base + longint'($urandom) % (span / 2 + 1);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 99);
          if (noise) cur = longint'(int'($urandom));
          else if (r < 85) cur = cur + longint'($urandom) % (2 * span / len + 1);
          else if (r >= 93) cur = cur - longint'($urandom) % (span / 4 + 1);
          v = cur;
          put_knot(v, (k == len - 1) && ($urandom_range(0, 19) != 0));
        end
      end
    end
    put_drain();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (schedule.size() != 0 || knot_if.valid || pending_points.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (pending_points.size() != 0)
      report($sformatf("%0d points never arrived", pending_points.size()));
    $display("Covered %0d knots, %0d points and %0d register writes", knots_taken,
             points_seen, writes_taken);
    $display("Subdivision extremes, trim edge cases and %0d long output hold-offs exercised",
             holds_done);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
